### hdl/dlf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dlf_pkg
// Shared types and constants of the delimiter line framer.
// ---------------------------------------------------------------------------
package dlf_pkg;

    localparam int unsigned DELIM_SLOTS = 16;

    localparam logic [1:0] CFG_IDX_DELIM_LOW  = 2'd0;
    localparam logic [1:0] CFG_IDX_DELIM_HIGH = 2'd1;
    localparam logic [1:0] CFG_IDX_DELIM_LEN  = 2'd2;

    localparam logic [63:0] DELIM_LOW_RST  = 64'h0000_0000_0000_0A0D;
    localparam logic [55:0] DELIM_HIGH_RST = 56'h0;
    localparam logic [3:0]  DELIM_LEN_RST  = 4'd2;

    typedef struct packed {
        logic load_byte;
        logic load_next;
        logic active;
    } dlf_cell_ctrl_t;

    typedef struct packed {
        logic       line_end;
        logic       byte_valid;
        logic [7:0] out_byte;
    } dlf_result_t;

endpackage
`default_nettype wire

### hdl/dlf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dlf_cell
// One window position: holds a pending byte, takes the new stream byte or
// its right neighbor's byte, and compares itself with its delimiter byte.
// ---------------------------------------------------------------------------
module dlf_cell
    import dlf_pkg::*;
(
    input  wire logic           aclk,
    input  wire dlf_cell_ctrl_t ctrl,
    input  wire logic [7:0]     in_byte,
    input  wire logic [7:0]     next_byte,
    input  wire logic [7:0]     delim_byte,
    output logic [7:0]          cell_byte,
    output logic                cell_eq
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (ctrl.load_byte) begin
            byte_next = in_byte;
        end else if (ctrl.load_next) begin
            byte_next = next_byte;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;
    assign cell_eq   = !ctrl.active || (byte_reg == delim_byte);

endmodule
`default_nettype wire

### hdl/dlf_out_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dlf_out_skid
// Output register with a skid entry, so the input side can take one more beat
// while a finished result waits on the master side.
// ---------------------------------------------------------------------------
module dlf_out_skid
    import dlf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        res_push,
    input  wire dlf_result_t res_data,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output dlf_result_t      out_data
);

    logic        main_valid_reg;
    logic        main_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    dlf_result_t main_reg;
    dlf_result_t main_next;
    dlf_result_t skid_reg;
    dlf_result_t skid_next;
    logic        main_free;

    assign main_free = !main_valid_reg || out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (main_free) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (res_push) begin
            if (main_free) begin
                main_next       = res_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = res_data;
                skid_valid_next = 1'b1;
            end
        end else if (out_ready) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule
`default_nettype wire

### hdl/delimiter_line_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// delimiter_line_framer
// Splits a byte stream into lines at a configurable delimiter of up to
// MAX_DELIM bytes, dropping the delimiter and marking each line end.
// ---------------------------------------------------------------------------
// Results to the master side are registered in dlf_out_skid. Throughput:
// one byte per cycle while the master side is not stalled, set by the
// combinational parallel compare across the window cells; a skid entry absorbs one master stall.
// Reset clears the pending count and output valids and loads the delimiter
// CR LF with length two; the window bytes themselves are not reset.
// ---------------------------------------------------------------------------
module delimiter_line_framer
    import dlf_pkg::*;
#(
    parameter int unsigned MAX_DELIM = 15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic [1:0]       m_tuser,   // [0] byte_valid, [1] line_end
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int unsigned NCELL = (MAX_DELIM > 1) ? MAX_DELIM - 1 : 1;
    localparam int unsigned CNT_W = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;

    logic [63:0]      dlm_low_reg;
    logic [55:0]      dlm_high_reg;
    logic [3:0]       dlm_len_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic [7:0]       dlm [DELIM_SLOTS];
    logic [3:0]       len_act;
    logic [3:0]       keep;
    logic [3:0]       cnt_ext;
    logic             accept;
    logic             cfg_fire;
    logic             filling;
    logic             match;
    logic             all_eq;
    logic             shift;
    logic             res_push;
    dlf_result_t      res_data;
    dlf_result_t      out_data;

    dlf_cell_ctrl_t   ctrl     [NCELL];
    logic [7:0]       cell_byte[NCELL];
    logic [NCELL-1:0] cell_eq;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        for (int k = 0; k < DELIM_SLOTS; k++) begin
            if (k < 8) begin
                dlm[k] = dlm_low_reg[8*k +: 8];
            end else if (k < 15) begin
                dlm[k] = dlm_high_reg[8*(k-8) +: 8];
            end else begin
                dlm[k] = 8'h00;
            end
        end
    end

    assign len_act = (dlm_len_reg > 4'(MAX_DELIM)) ? 4'(MAX_DELIM) : dlm_len_reg;
    assign keep    = len_act - 4'd1;
    assign cnt_ext = 4'(cnt_reg);
    assign filling = (len_act != 4'd0) && (cnt_ext < keep);
    assign all_eq  = &cell_eq;
    assign match   = (len_act != 4'd0) && !filling && all_eq && (s_tdata == dlm[keep]);
    assign shift   = accept && (len_act != 4'd0) && !filling && !match;

    always_comb begin
        for (int i = 0; i < NCELL; i++) begin
            ctrl[i].active    = (4'(i) < keep);
            ctrl[i].load_byte = (accept && filling && (cnt_ext == 4'(i)))
                                || (shift && (4'(i) == keep - 4'd1));
            ctrl[i].load_next = shift && (4'(i) < keep - 4'd1);
        end
    end

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic [7:0] nb;
        if (g + 1 < NCELL) begin : g_mid
            assign nb = cell_byte[g+1];
        end else begin : g_end
            assign nb = s_tdata;
        end
        dlf_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl[g]),
            .in_byte   (s_tdata),
            .next_byte (nb),
            .delim_byte(dlm[g]),
            .cell_byte (cell_byte[g]),
            .cell_eq   (cell_eq[g])
        );
    end

    always_comb begin
        res_push            = accept && !filling;
        res_data.line_end   = match;
        res_data.byte_valid = !match;
        if (match) begin
            res_data.out_byte = 8'h00;
        end else if (len_act == 4'd0 || keep == 4'd0) begin
            res_data.out_byte = s_tdata;
        end else begin
            res_data.out_byte = cell_byte[0];
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cfg_fire && cfg_index == CFG_IDX_DELIM_LEN) begin
            cnt_next = '0;
        end else if (accept && len_act != 4'd0) begin
            if (filling) begin
                cnt_next = CNT_W'(cnt_ext + 4'd1);
            end else if (match) begin
                cnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dlm_low_reg  <= DELIM_LOW_RST;
            dlm_high_reg <= DELIM_HIGH_RST;
            dlm_len_reg  <= DELIM_LEN_RST;
            cnt_reg      <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (cfg_fire) begin
                case (cfg_index)
                    CFG_IDX_DELIM_LOW:  dlm_low_reg  <= cfg_data;
                    CFG_IDX_DELIM_HIGH: dlm_high_reg <= cfg_data[55:0];
                    CFG_IDX_DELIM_LEN:  dlm_len_reg  <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    dlf_out_skid u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_push (res_push),
        .res_data (res_data),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (out_data)
    );

    assign m_tdata = out_data.out_byte;
    assign m_tuser = {out_data.line_end, out_data.byte_valid};

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_act == 4'd0) || (cnt_ext <= keep))
        else $error("pending count beyond window length");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |=> m_tvalid)
        else $error("result beat lost");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] != m_tuser[1]))
        else $error("result is neither a line byte nor a line end");

endmodule
`default_nettype wire
